@@ design/pcms_pkg.sv @@
// ----------------------------------------------------------------------------
// pcms_pkg: shared types and constants for the point charge motion step
// Fixed-point format, register indexes, input codes and the command and
// status records that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pcms_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int ROOT_STEPS = 32;
    localparam int DIV_STEPS  = 64;
    localparam int CAP_W      = 62 - FRAC_BITS;
    localparam int UNIT_W     = FRAC_BITS + 1;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [1:0] REG_GAIN     = 2'd0;
    localparam logic [1:0] REG_INV_MASS = 2'd1;
    localparam logic [1:0] REG_TSTEP    = 2'd2;
    localparam logic [1:0] REG_MIN_DIST = 2'd3;

    localparam logic IN_PLACE  = 1'b0;
    localparam logic IN_SOURCE = 1'b1;

    localparam logic [1:0] DIV_Q1 = 2'd0;
    localparam logic [1:0] DIV_Q2 = 2'd1;
    localparam logic [1:0] DIV_UX = 2'd2;
    localparam logic [1:0] DIV_UY = 2'd3;

    localparam logic [1:0] EPH_ACC = 2'd0;
    localparam logic [1:0] EPH_VEL = 2'd1;
    localparam logic [1:0] EPH_POS = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_SQX, S_SQY, S_ROOT, S_DIST, S_CHK, S_DIVI, S_DIVS, S_DIVE,
        S_MAG, S_ADD, S_EUL, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_PLACE, OP_LOAD, OP_SQX, OP_SQY, OP_ROOT, OP_DIST,
        OP_DIV_INIT, OP_DIV_STEP, OP_DIV_END, OP_MAG, OP_ADD, OP_EMUL,
        OP_ESAT, OP_EMIT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] sel;
        logic       axis;
        logic [1:0] phase;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic last;
    } t_stat;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -50'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

`default_nettype wire

@@ design/pcms_ctrl.sv @@
// ----------------------------------------------------------------------------
// pcms_ctrl: sequencer for the point charge motion step
// Steps the datapath through distance, divisions, accumulation and the
// Euler update, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module pcms_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_valid,
    input  wire logic           i_s_op,
    output logic                o_s_ready,
    output logic                o_m_valid,
    input  wire logic           i_m_ready,
    input  wire pcms_pkg::t_stat i_stat,
    output pcms_pkg::t_cmd      o_cmd
);

    pcms_pkg::t_state r_state, n_state;
    logic [pcms_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0] r_sel, n_sel;
    logic [2:0] r_ph, n_ph;
    logic r_axis, n_axis;
    logic r_ov, n_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcms_pkg::S_IDLE;
            r_cnt   <= '0;
            r_sel   <= '0;
            r_ph    <= '0;
            r_axis  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sel   <= n_sel;
            r_ph    <= n_ph;
            r_axis  <= n_axis;
            r_ov    <= n_ov;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_sel   = r_sel;
        n_ph    = r_ph;
        n_axis  = r_axis;
        n_ov    = r_ov && !i_m_ready;
        o_s_ready = 1'b0;
        o_cmd.op    = pcms_pkg::OP_NONE;
        o_cmd.sel   = r_sel;
        o_cmd.axis  = r_axis;
        o_cmd.phase = r_ph[2:1];
        unique case (r_state)
            pcms_pkg::S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    if (i_s_op == pcms_pkg::IN_SOURCE) begin
                        o_cmd.op = pcms_pkg::OP_LOAD;
                        n_state  = pcms_pkg::S_SQX;
                    end else begin
                        o_cmd.op = pcms_pkg::OP_PLACE;
                    end
                end
            end
            pcms_pkg::S_SQX: begin
                o_cmd.op = pcms_pkg::OP_SQX;
                n_state  = pcms_pkg::S_SQY;
            end
            pcms_pkg::S_SQY: begin
                o_cmd.op = pcms_pkg::OP_SQY;
                n_cnt    = '0;
                n_state  = pcms_pkg::S_ROOT;
            end
            pcms_pkg::S_ROOT: begin
                o_cmd.op = pcms_pkg::OP_ROOT;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == pcms_pkg::CNT_W'(pcms_pkg::ROOT_STEPS - 1)) begin
                    n_state = pcms_pkg::S_DIST;
                end
            end
            pcms_pkg::S_DIST: begin
                o_cmd.op = pcms_pkg::OP_DIST;
                n_state  = pcms_pkg::S_CHK;
            end
            pcms_pkg::S_CHK: begin
                n_sel  = pcms_pkg::DIV_Q1;
                n_ph   = '0;
                n_axis = 1'b0;
                if (!i_stat.skip) begin
                    n_state = pcms_pkg::S_DIVI;
                end else if (i_stat.last) begin
                    n_state = pcms_pkg::S_EUL;
                end else begin
                    n_state = pcms_pkg::S_IDLE;
                end
            end
            pcms_pkg::S_DIVI: begin
                o_cmd.op = pcms_pkg::OP_DIV_INIT;
                n_cnt    = '0;
                n_state  = pcms_pkg::S_DIVS;
            end
            pcms_pkg::S_DIVS: begin
                o_cmd.op = pcms_pkg::OP_DIV_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == pcms_pkg::CNT_W'(pcms_pkg::DIV_STEPS - 1)) begin
                    n_state = pcms_pkg::S_DIVE;
                end
            end
            pcms_pkg::S_DIVE: begin
                o_cmd.op = pcms_pkg::OP_DIV_END;
                if (r_sel == pcms_pkg::DIV_UY) begin
                    n_axis  = 1'b0;
                    n_state = pcms_pkg::S_MAG;
                end else begin
                    n_sel   = r_sel + 1'b1;
                    n_state = pcms_pkg::S_DIVI;
                end
            end
            pcms_pkg::S_MAG: begin
                o_cmd.op = pcms_pkg::OP_MAG;
                n_state  = pcms_pkg::S_ADD;
            end
            pcms_pkg::S_ADD: begin
                o_cmd.op = pcms_pkg::OP_ADD;
                n_ph     = '0;
                if (!r_axis) begin
                    n_axis  = 1'b1;
                    n_state = pcms_pkg::S_MAG;
                end else begin
                    n_axis  = 1'b0;
                    n_state = i_stat.last ? pcms_pkg::S_EUL : pcms_pkg::S_IDLE;
                end
            end
            pcms_pkg::S_EUL: begin
                o_cmd.op = r_ph[0] ? pcms_pkg::OP_ESAT : pcms_pkg::OP_EMUL;
                if (r_ph == 3'd5) begin
                    n_ph = '0;
                    if (r_axis) begin
                        n_state = pcms_pkg::S_OUT;
                    end else begin
                        n_axis = 1'b1;
                    end
                end else begin
                    n_ph = r_ph + 1'b1;
                end
            end
            pcms_pkg::S_OUT: begin
                if (!r_ov || i_m_ready) begin
                    o_cmd.op = pcms_pkg::OP_EMIT;
                    n_ov     = 1'b1;
                    n_state  = pcms_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pcms_pkg::S_IDLE;
            end
        endcase
    end

    assign o_m_valid = r_ov;

`ifndef SYNTHESIS
    a_busy_after_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_valid && o_s_ready && i_s_op == pcms_pkg::IN_SOURCE) |=> !o_s_ready)
        else $error("input taken while a source word is in work");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == pcms_pkg::OP_EMIT) |-> (!r_ov || i_m_ready))
        else $error("result overwritten before it was taken");
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == pcms_pkg::OP_EMIT) |=> o_m_valid)
        else $error("result emitted without valid");
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pcms_pkg::S_EUL) |-> (r_ph <= 3'd5))
        else $error("Euler phase out of range");
`endif

endmodule

`default_nettype wire

@@ design/pcms_dp.sv @@
// ----------------------------------------------------------------------------
// pcms_dp: datapath for the point charge motion step
// Holds probe state, field sums and registers, a bit-serial square root,
// a shared restoring divider and the multiplier of the Euler update.
// ----------------------------------------------------------------------------
`default_nettype none

module pcms_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_addr,
    input  wire logic [31:0]        i_cfg_wdata,
    input  wire pcms_pkg::t_cmd     i_cmd,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic [1:0]         i_sign,
    input  wire logic               i_last,
    output pcms_pkg::t_stat         o_stat,
    output logic signed [31:0]      o_out_x,
    output logic signed [31:0]      o_out_y
);

    localparam int F = pcms_pkg::FRAC_BITS;
    localparam logic [63:0] CAP = (64'd1 << pcms_pkg::CAP_W) - 64'd1;
    localparam logic [63:0] ONE = 64'd1 << F;

    logic [31:0] r_gain, r_inv, r_dt, r_min;
    logic signed [31:0] r_pos [2];
    logic signed [31:0] r_vel [2];
    logic signed [31:0] r_sum [2];
    logic signed [31:0] r_acc;
    logic [32:0] r_ax, r_ay;
    logic r_negx, r_negy, r_sneg, r_szero, r_last, r_skip, r_s;
    logic [63:0] r_sq, r_srem, r_root, r_bit;
    logic [32:0] r_d;
    logic [32:0] r_drem;
    logic [63:0] r_quo;
    logic [pcms_pkg::CAP_W-1:0] r_q1, r_q2;
    logic [pcms_pkg::UNIT_W-1:0] r_ux, r_uy;
    logic [63:0] r_mprod;
    logic signed [64:0] r_eprod;
    logic signed [31:0] r_out_x, r_out_y;

    logic signed [32:0] dx, dy;
    logic hs;
    logic [31:0] hx, hy;
    logic [63:0] sq_sum, try_v, divd;
    logic [33:0] shr;
    logic [32:0] root_d;
    logic [63:0] q_cl;
    logic [47:0] mag;
    logic signed [49:0] contrib, sum_n, e_shift, e_n;
    logic signed [32:0] ma, mb;
    logic [pcms_pkg::UNIT_W-1:0] usel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= 32'(64'd1 << F);
            r_inv  <= 32'(64'd1 << F);
            r_dt   <= 32'(((64'd1 << F) + 64'd5) / 64'd10);
            r_min  <= 32'(64'd1 << (F - 1));
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                pcms_pkg::REG_GAIN:     r_gain <= i_cfg_wdata;
                pcms_pkg::REG_INV_MASS: r_inv  <= i_cfg_wdata;
                pcms_pkg::REG_TSTEP:    r_dt   <= i_cfg_wdata;
                pcms_pkg::REG_MIN_DIST: r_min  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        dx = 33'(r_pos[0]) - 33'(i_pos_x);
        dy = 33'(r_pos[1]) - 33'(i_pos_y);
        hs = r_ax[32] | r_ax[31] | r_ay[32] | r_ay[31];
        hx = 32'(r_ax >> hs);
        hy = 32'(r_ay >> hs);
        sq_sum = r_sq + 64'(hy) * 64'(hy);
        try_v = r_root + r_bit;
        root_d = 33'(r_root[31:0]) << r_s;
        shr = {r_drem, r_quo[63]};
        unique case (i_cmd.sel)
            pcms_pkg::DIV_Q1: divd = 64'(r_gain) << F;
            pcms_pkg::DIV_Q2: divd = 64'(r_q1) << F;
            pcms_pkg::DIV_UX: divd = 64'(r_ax) << F;
            default:          divd = 64'(r_ay) << F;
        endcase
        if (i_cmd.sel == pcms_pkg::DIV_Q1 || i_cmd.sel == pcms_pkg::DIV_Q2) begin
            q_cl = (r_quo > CAP) ? CAP : r_quo;
        end else begin
            q_cl = (r_quo > ONE) ? ONE : r_quo;
        end
        usel = i_cmd.axis ? r_uy : r_ux;
        mag = 48'(r_mprod >> F);
        contrib = ((i_cmd.axis ? r_negy : r_negx) ^ r_sneg) ? -50'(mag) : 50'(mag);
        sum_n = 50'(r_sum[i_cmd.axis]) + contrib;
        unique case (i_cmd.phase)
            pcms_pkg::EPH_ACC: begin
                ma = 33'(r_sum[i_cmd.axis]);
                mb = signed'({1'b0, r_inv});
            end
            pcms_pkg::EPH_VEL: begin
                ma = 33'(r_acc);
                mb = signed'({1'b0, r_dt});
            end
            default: begin
                ma = 33'(r_vel[i_cmd.axis]);
                mb = signed'({1'b0, r_dt});
            end
        endcase
        e_shift = 50'(r_eprod >>> F);
        unique case (i_cmd.phase)
            pcms_pkg::EPH_ACC: e_n = e_shift;
            pcms_pkg::EPH_VEL: e_n = e_shift + 50'(r_vel[i_cmd.axis]);
            default:           e_n = e_shift + 50'(r_pos[i_cmd.axis]);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos[0] <= '0;
            r_pos[1] <= '0;
            r_vel[0] <= '0;
            r_vel[1] <= '0;
            r_sum[0] <= '0;
            r_sum[1] <= '0;
        end else begin
            unique case (i_cmd.op)
                pcms_pkg::OP_PLACE: begin
                    r_pos[0] <= i_pos_x;
                    r_pos[1] <= i_pos_y;
                    r_vel[0] <= '0;
                    r_vel[1] <= '0;
                    r_sum[0] <= '0;
                    r_sum[1] <= '0;
                end
                pcms_pkg::OP_ADD: begin
                    r_sum[i_cmd.axis] <= pcms_pkg::sat32(sum_n);
                end
                pcms_pkg::OP_ESAT: begin
                    if (i_cmd.phase == pcms_pkg::EPH_VEL) begin
                        r_vel[i_cmd.axis] <= pcms_pkg::sat32(e_n);
                    end else if (i_cmd.phase == pcms_pkg::EPH_POS) begin
                        r_pos[i_cmd.axis] <= pcms_pkg::sat32(e_n);
                    end
                end
                pcms_pkg::OP_EMIT: begin
                    r_sum[0] <= '0;
                    r_sum[1] <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            pcms_pkg::OP_LOAD: begin
                r_ax    <= dx[32] ? 33'(-dx) : 33'(dx);
                r_ay    <= dy[32] ? 33'(-dy) : 33'(dy);
                r_negx  <= dx[32];
                r_negy  <= dy[32];
                r_sneg  <= i_sign[1];
                r_szero <= (i_sign == 2'b00);
                r_last  <= i_last;
            end
            pcms_pkg::OP_SQX: begin
                r_sq <= 64'(hx) * 64'(hx);
                r_s  <= hs;
            end
            pcms_pkg::OP_SQY: begin
                r_srem <= sq_sum;
                r_root <= '0;
                r_bit  <= 64'd1 << 62;
            end
            pcms_pkg::OP_ROOT: begin
                if (r_srem >= try_v) begin
                    r_srem <= r_srem - try_v;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            pcms_pkg::OP_DIST: begin
                r_d    <= root_d;
                r_skip <= r_szero || (root_d <= 33'(r_min));
            end
            pcms_pkg::OP_DIV_INIT: begin
                r_drem <= '0;
                r_quo  <= divd;
            end
            pcms_pkg::OP_DIV_STEP: begin
                if (shr >= {1'b0, r_d}) begin
                    r_drem <= 33'(shr - {1'b0, r_d});
                    r_quo  <= {r_quo[62:0], 1'b1};
                end else begin
                    r_drem <= shr[32:0];
                    r_quo  <= {r_quo[62:0], 1'b0};
                end
            end
            pcms_pkg::OP_DIV_END: begin
                unique case (i_cmd.sel)
                    pcms_pkg::DIV_Q1: r_q1 <= q_cl[pcms_pkg::CAP_W-1:0];
                    pcms_pkg::DIV_Q2: r_q2 <= q_cl[pcms_pkg::CAP_W-1:0];
                    pcms_pkg::DIV_UX: r_ux <= q_cl[pcms_pkg::UNIT_W-1:0];
                    default:          r_uy <= q_cl[pcms_pkg::UNIT_W-1:0];
                endcase
            end
            pcms_pkg::OP_MAG: begin
                r_mprod <= 64'(r_q2) * 64'(usel);
            end
            pcms_pkg::OP_EMUL: begin
                r_eprod <= 65'(ma) * 65'(mb);
            end
            pcms_pkg::OP_ESAT: begin
                if (i_cmd.phase == pcms_pkg::EPH_ACC) begin
                    r_acc <= pcms_pkg::sat32(e_n);
                end
            end
            pcms_pkg::OP_EMIT: begin
                r_out_x <= r_pos[0];
                r_out_y <= r_pos[1];
            end
            default: ;
        endcase
    end

    assign o_stat.skip = r_skip;
    assign o_stat.last = r_last;
    assign o_out_x = r_out_x;
    assign o_out_y = r_out_y;

endmodule

`default_nettype wire

@@ design/point_charge_motion_step.sv @@
// ----------------------------------------------------------------------------
// point_charge_motion_step: probe charge in the field of streamed sources
// Accumulates the saturated Coulomb field of source words and takes an
// Euler step of the probe on the last source of each run.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Contents
// s        in         i_s_tvalid/o_s_tready  position, sign, operation, last
// m        out        o_m_tvalid/i_m_tready  new probe position
// cfg      in         i_cfg_we               field_gain, inverse_mass, ...
//
// A place word keeps the block idle. A source word runs the 32-step square
// root and four 64-step divisions on one shared divider; a source at or
// within the minimum distance, or of zero sign, skips the divisions. A last
// source adds the Euler update and the output register. Reset is
// synchronous and needs no clearing pass. The next word is taken while a
// result waits; the block stalls only before writing a new result.
// ----------------------------------------------------------------------------
`default_nettype none

module point_charge_motion_step (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [71:0] i_s_tdata,  // pos_x, pos_y, source_sign, zero fill
    input  wire logic        i_s_tuser,  // operation
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [63:0]      o_m_tdata,  // probe_x_out, probe_y_out
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_wdata
);

    pcms_pkg::t_cmd  cmd;
    pcms_pkg::t_stat stat;
    logic signed [31:0] out_x, out_y;

    pcms_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .i_s_op    (i_s_tuser),
        .o_s_ready (o_s_tready),
        .o_m_valid (o_m_tvalid),
        .i_m_ready (i_m_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    pcms_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .i_pos_x     (signed'(i_s_tdata[31:0])),
        .i_pos_y     (signed'(i_s_tdata[63:32])),
        .i_sign      (i_s_tdata[65:64]),
        .i_last      (i_s_tlast),
        .o_stat      (stat),
        .o_out_x     (out_x),
        .o_out_y     (out_y)
    );

    assign o_m_tdata = {out_y, out_x};

endmodule

`default_nettype wire
